FILE: rtl/cprg_pkg.sv
// Shared widths, stage counts, register codes and pipeline types of the pick-ray generator.
package cprg_pkg;

   // Fixed-point formats
   localparam int FRAC_BITS = 12;
   localparam int PORT_BITS = 12;
   localparam int SIZE_W    = PORT_BITS + 1;
   localparam int VEC_W     = 20;
   localparam int BND_W     = 16;
   localparam int NEAR_W    = 19;
   localparam int BNDS_W    = 4 * BND_W;
   localparam int VECS_W    = 3 * VEC_W;

   // Configuration port
   localparam int CSR_W     = 64;
   localparam int CSR_IDX_W = 3;

   // Datapath widths
   localparam int MAG_W       = 28;
   localparam int SQ_W        = 2 * MAG_W;
   localparam int DIV_NUM_W   = MAG_W + FRAC_BITS;
   localparam int DIV_DEN_W   = MAG_W;
   localparam int DIV_STAGES  = FRAC_BITS + 1;
   localparam int SQRT_STAGES = MAG_W;

   // Cycles from accepted request to result strobe
   localparam int CPRG_LATENCY = 2 * DIV_STAGES + SQRT_STAGES + 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE  = 3'd0,
      CSR_NEAR  = 3'd1,
      CSR_PBND  = 3'd2,
      CSR_OBND  = 3'd3,
      CSR_EYE   = 3'd4,
      CSR_LEFT  = 3'd5,
      CSR_UP    = 3'd6,
      CSR_VIEW  = 3'd7
   } csr_index_type;

   // Data carried alongside the square root
   typedef struct packed {
      logic                  ok;
      logic [2:0]            neg;
      logic [2:0][MAG_W-1:0] mag;
      logic [2:0][VEC_W-1:0] org;
   } side_type;

   // Data carried alongside the normalizing dividers
   typedef struct packed {
      logic                  ok;
      logic [2:0]            neg;
      logic                  flat;
      logic [2:0][VEC_W-1:0] org;
   } tail_type;

endpackage

FILE: rtl/cprg_div.sv
// Pipelined restoring divider, one quotient bit per stage, quotient known below 2^DIV_STAGES.
module cprg_div (
   input  logic                            clock,
   input  logic [cprg_pkg::DIV_NUM_W-1:0]  num,
   input  logic [cprg_pkg::DIV_DEN_W-1:0]  den,
   output logic [cprg_pkg::DIV_STAGES-1:0] quo
);
   import cprg_pkg::*;

   logic [DIV_NUM_W-1:0]  rem_ff [DIV_STAGES];
   logic [DIV_DEN_W-1:0]  den_ff [DIV_STAGES];
   logic [DIV_STAGES-1:0] quo_ff [DIV_STAGES];

   genvar k;
   generate
      for (k = 0; k < DIV_STAGES; k++) begin : stage
         logic [DIV_NUM_W-1:0]  rem_src;
         logic [DIV_NUM_W-1:0]  trial;
         logic [DIV_DEN_W-1:0]  den_src;
         logic [DIV_STAGES-1:0] quo_src;
         logic [DIV_NUM_W-1:0]  rem_in;
         logic [DIV_STAGES-1:0] quo_in;
         logic                  ge;

         if (k == 0) begin : first
            assign rem_src = num;
            assign den_src = den;
            assign quo_src = '0;
         end else begin : rest
            assign rem_src = rem_ff[k-1];
            assign den_src = den_ff[k-1];
            assign quo_src = quo_ff[k-1];
         end

         // Try subtracting the shifted divisor for this quotient bit
         assign trial  = DIV_NUM_W'(den_src) << (DIV_STAGES - 1 - k);
         assign ge     = (rem_src >= trial);
         assign rem_in = ge ? rem_src - trial : rem_src;
         assign quo_in = quo_src | (ge ? (DIV_STAGES'(1) << (DIV_STAGES - 1 - k)) : '0);

         always_ff @(posedge clock) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_src;
            quo_ff[k] <= quo_in;
         end
      end
   endgenerate

   assign quo = quo_ff[DIV_STAGES-1];

endmodule

FILE: rtl/camera_pick_ray_generator.sv
// Path from an accepted request to its result strobe: two ranks of 13-stage dividers,
// a 28-stage square root and eight arithmetic stages around them.
// Throughput: one request per cycle; busy never rises, the pipeline always advances.
// Each result shows on the rsp_ ports for one cycle with rsp_valid high; it cannot be stalled.
// Reset (synchronous, active high) empties the pipeline and restores all camera registers.
module camera_pick_ray_generator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [cprg_pkg::PORT_BITS-1:0]      req_pixel_x,
   input  logic [cprg_pkg::PORT_BITS-1:0]      req_pixel_y,
   input  logic [cprg_pkg::SIZE_W-1:0]         req_port_width,
   input  logic [cprg_pkg::SIZE_W-1:0]         req_port_height,
   output logic                                rsp_valid,
   output logic                                rsp_ray_valid,
   output logic signed [cprg_pkg::VEC_W-1:0]   rsp_origin_x,
   output logic signed [cprg_pkg::VEC_W-1:0]   rsp_origin_y,
   output logic signed [cprg_pkg::VEC_W-1:0]   rsp_origin_z,
   output logic signed [cprg_pkg::VEC_W-1:0]   rsp_ray_dir_x,
   output logic signed [cprg_pkg::VEC_W-1:0]   rsp_ray_dir_y,
   output logic signed [cprg_pkg::VEC_W-1:0]   rsp_ray_dir_z,
   input  logic                                csr_we,
   input  logic [cprg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cprg_pkg::CSR_W-1:0]          csr_wdata
);
   import cprg_pkg::*;

   localparam int LP_W   = FRAC_BITS + 2 + BND_W;
   localparam int LS_W   = LP_W + 2;
   localparam int U_W    = BND_W + 1;
   localparam int PN_W   = 2 * VEC_W;
   localparam int PU_W   = U_W + VEC_W;
   localparam int ACC_W  = PN_W + 2;
   localparam int SHR_W  = ACC_W - FRAC_BITS;
   localparam int Q_LAST = DIV_STAGES - 1;
   localparam int R_LAST = SQRT_STAGES - 1;

   function automatic logic signed [VEC_W-1:0] sat_vec(input logic signed [SHR_W-1:0] v);
      logic [SHR_W-VEC_W:0] head;
      head = v[SHR_W-1:VEC_W-1];
      if (&head || ~|head) return v[VEC_W-1:0];
      return v[SHR_W-1] ? {1'b1, {(VEC_W-1){1'b0}}} : {1'b0, {(VEC_W-1){1'b1}}};
   endfunction

   // ---------------- camera registers ----------------
   logic              mode_ff;
   logic [NEAR_W-1:0] near_ff;
   logic [BNDS_W-1:0] pbnd_ff, obnd_ff;
   logic [VECS_W-1:0] eye_ff, left_ff, up_ff, view_ff;

   // Write the addressed register; ignore unused bits
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b1;
         near_ff <= NEAR_W'(1) << FRAC_BITS;
         pbnd_ff <= 64'hF800_0800_F800_0800;
         obnd_ff <= 64'hF800_0800_F800_0800;
         eye_ff  <= '0;
         left_ff <= {20'h01000, 20'h00000, 20'h00000};
         up_ff   <= {20'h00000, 20'h01000, 20'h00000};
         view_ff <= {20'h00000, 20'h00000, 20'h01000};
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODE: mode_ff <= csr_wdata[0];
            CSR_NEAR: near_ff <= csr_wdata[NEAR_W-1:0];
            CSR_PBND: pbnd_ff <= csr_wdata;
            CSR_OBND: obnd_ff <= csr_wdata;
            CSR_EYE:  eye_ff  <= csr_wdata[VECS_W-1:0];
            CSR_LEFT: left_ff <= csr_wdata[VECS_W-1:0];
            CSR_UP:   up_ff   <= csr_wdata[VECS_W-1:0];
            CSR_VIEW: view_ff <= csr_wdata[VECS_W-1:0];
            default: ;
         endcase
      end
   end

   // Camera vector components, x first
   logic signed [VEC_W-1:0] eye_c [3];
   logic signed [VEC_W-1:0] left_c [3];
   logic signed [VEC_W-1:0] up_c [3];
   logic signed [VEC_W-1:0] view_c [3];

   genvar g;
   generate
      for (g = 0; g < 3; g++) begin : comp
         assign eye_c[g]  = eye_ff[VEC_W*(2-g) +: VEC_W];
         assign left_c[g] = left_ff[VEC_W*(2-g) +: VEC_W];
         assign up_c[g]   = up_ff[VEC_W*(2-g) +: VEC_W];
         assign view_c[g] = view_ff[VEC_W*(2-g) +: VEC_W];
      end
   endgenerate

   assign busy = 1'b0;

   // ---------------- stage 1: viewport check, divider operands ----------------
   logic                 accept;
   logic                 ok_in;
   logic [SIZE_W-1:0]    nx_in, ny_in;
   logic [DIV_NUM_W-1:0] numx_in, numy_in;
   logic                 vld1_ff, ok1_ff;
   logic [DIV_NUM_W-1:0] numx_ff, numy_ff;
   logic [SIZE_W-1:0]    denx_ff, deny_ff;

   assign accept = start & ~busy;

   always_comb begin
      ok_in   = (req_port_width != '0) && (req_port_height != '0) &&
                ({1'b0, req_pixel_x} < req_port_width) &&
                ({1'b0, req_pixel_y} < req_port_height);
      nx_in   = req_port_width - SIZE_W'(1) - {1'b0, req_pixel_x};
      ny_in   = req_port_height - SIZE_W'(1) - {1'b0, req_pixel_y};
      numx_in = (DIV_NUM_W'(nx_in) << FRAC_BITS) + DIV_NUM_W'(req_port_width >> 1);
      numy_in = (DIV_NUM_W'(ny_in) << FRAC_BITS) + DIV_NUM_W'(req_port_height >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) vld1_ff <= 1'b0;
      else vld1_ff <= accept;
   end

   always_ff @(posedge clock) begin
      ok1_ff  <= ok_in;
      numx_ff <= numx_in;
      numy_ff <= numy_in;
      denx_ff <= req_port_width;
      deny_ff <= req_port_height;
   end

   // ---------------- viewport fractions ----------------
   logic [DIV_STAGES-1:0] px, py;
   logic                  fvld_ff [DIV_STAGES];
   logic                  fok_ff [DIV_STAGES];

   cprg_div u_div_x (
      .clock (clock),
      .num   (numx_ff),
      .den   (DIV_DEN_W'(denx_ff)),
      .quo   (px)
   );

   cprg_div u_div_y (
      .clock (clock),
      .num   (numy_ff),
      .den   (DIV_DEN_W'(deny_ff)),
      .quo   (py)
   );

   // Advance request flags beside the dividers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_STAGES; i++) fvld_ff[i] <= 1'b0;
      end else begin
         fvld_ff[0] <= vld1_ff;
         for (int i = 1; i < DIV_STAGES; i++) fvld_ff[i] <= fvld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      fok_ff[0] <= ok1_ff;
      for (int i = 1; i < DIV_STAGES; i++) fok_ff[i] <= fok_ff[i-1];
   end

   // ---------------- lerp products ----------------
   logic [BNDS_W-1:0]     bnd;
   logic [DIV_STAGES-1:0] omx, omy;
   logic signed [LP_W-1:0] ml_in, mr_in, mb_in, mt_in;
   logic signed [LP_W-1:0] ml_ff, mr_ff, mb_ff, mt_ff;
   logic                  l1_vld_ff, l1_ok_ff;

   always_comb begin
      bnd   = mode_ff ? pbnd_ff : obnd_ff;
      omx   = (DIV_STAGES'(1) << FRAC_BITS) - px;
      omy   = (DIV_STAGES'(1) << FRAC_BITS) - py;
      ml_in = $signed({1'b0, omx}) * $signed(bnd[BND_W*3 +: BND_W]);
      mr_in = $signed({1'b0, px})  * $signed(bnd[BND_W*2 +: BND_W]);
      mb_in = $signed({1'b0, omy}) * $signed(bnd[BND_W*1 +: BND_W]);
      mt_in = $signed({1'b0, py})  * $signed(bnd[BND_W*0 +: BND_W]);
   end

   always_ff @(posedge clock) begin
      if (reset) l1_vld_ff <= 1'b0;
      else l1_vld_ff <= fvld_ff[Q_LAST];
   end

   always_ff @(posedge clock) begin
      l1_ok_ff <= fok_ff[Q_LAST];
      ml_ff    <= ml_in;
      mr_ff    <= mr_in;
      mb_ff    <= mb_in;
      mt_ff    <= mt_in;
   end

   // ---------------- lerp sums, round half up ----------------
   logic signed [LS_W-1:0] su_in, sv_in;
   logic signed [U_W-1:0]  u_ff, v_ff;
   logic                   l2_vld_ff, l2_ok_ff;

   always_comb begin
      su_in = LS_W'(ml_ff) + LS_W'(mr_ff) + $signed(LS_W'(1) << (FRAC_BITS - 1));
      sv_in = LS_W'(mb_ff) + LS_W'(mt_ff) + $signed(LS_W'(1) << (FRAC_BITS - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) l2_vld_ff <= 1'b0;
      else l2_vld_ff <= l1_vld_ff;
   end

   always_ff @(posedge clock) begin
      l2_ok_ff <= l1_ok_ff;
      u_ff     <= U_W'(su_in >>> FRAC_BITS);
      v_ff     <= U_W'(sv_in >>> FRAC_BITS);
   end

   // ---------------- vector products and sums ----------------
   logic signed [PN_W-1:0]  pn_ff [3];
   logic signed [PU_W-1:0]  pu_ff [3];
   logic signed [PU_W-1:0]  pv_ff [3];
   logic signed [MAG_W-1:0] cmp_ff [3];
   logic signed [VEC_W-1:0] org_ff [3];
   logic                    m1_vld_ff, m1_ok_ff, m2_vld_ff, m2_ok_ff;

   generate
      for (g = 0; g < 3; g++) begin : vsum
         logic signed [PN_W-1:0]  pn_in;
         logic signed [PU_W-1:0]  pu_in, pv_in;
         logic signed [ACC_W-1:0] acc_in;
         logic signed [SHR_W-1:0] shr_in;

         assign pn_in = $signed({1'b0, near_ff}) * view_c[g];
         assign pu_in = u_ff * left_c[g];
         assign pv_in = v_ff * up_c[g];

         // Add eye in orthographic mode, then round to the vector format
         assign acc_in = ACC_W'(pn_ff[g]) + ACC_W'(pu_ff[g]) + ACC_W'(pv_ff[g]) +
                         (mode_ff ? ACC_W'(0) : (ACC_W'(eye_c[g]) <<< FRAC_BITS)) +
                         $signed(ACC_W'(1) << (FRAC_BITS - 1));
         assign shr_in = SHR_W'(acc_in >>> FRAC_BITS);

         always_ff @(posedge clock) begin
            pn_ff[g]  <= pn_in;
            pu_ff[g]  <= pu_in;
            pv_ff[g]  <= pv_in;
            cmp_ff[g] <= MAG_W'(shr_in);
            org_ff[g] <= mode_ff ? eye_c[g] : sat_vec(shr_in);
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff <= 1'b0;
         m2_vld_ff <= 1'b0;
      end else begin
         m1_vld_ff <= l2_vld_ff;
         m2_vld_ff <= m1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      m1_ok_ff <= l2_ok_ff;
      m2_ok_ff <= m1_ok_ff;
   end

   // ---------------- magnitudes and squares ----------------
   side_type          side_in;
   logic [SQ_W-1:0]   sq_in [3];
   logic [SQ_W-1:0]   sq_ff [3];
   side_type          q_side_ff;
   logic              q_vld_ff;

   always_comb begin
      side_in.ok = m2_ok_ff;
      for (int i = 0; i < 3; i++) begin
         side_in.neg[i] = cmp_ff[i][MAG_W-1];
         side_in.mag[i] = cmp_ff[i][MAG_W-1] ? MAG_W'(-cmp_ff[i]) : MAG_W'(cmp_ff[i]);
         side_in.org[i] = org_ff[i];
         sq_in[i]       = side_in.mag[i] * side_in.mag[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) q_vld_ff <= 1'b0;
      else q_vld_ff <= m2_vld_ff;
   end

   always_ff @(posedge clock) begin
      q_side_ff <= side_in;
      for (int i = 0; i < 3; i++) sq_ff[i] <= sq_in[i];
   end

   // ---------------- sum of squares ----------------
   logic [SQ_W-1:0] ssum_ff;
   side_type        s_side_ff;
   logic            s_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) s_vld_ff <= 1'b0;
      else s_vld_ff <= q_vld_ff;
   end

   always_ff @(posedge clock) begin
      ssum_ff   <= sq_ff[0] + sq_ff[1] + sq_ff[2];
      s_side_ff <= q_side_ff;
   end

   // ---------------- square root, one result bit per stage ----------------
   logic [SQ_W-1:0] rn_ff [SQRT_STAGES];
   logic [SQ_W-1:0] rr_ff [SQRT_STAGES];
   side_type        rside_ff [SQRT_STAGES];
   logic            rvld_ff [SQRT_STAGES];

   generate
      for (g = 0; g < SQRT_STAGES; g++) begin : root
         localparam logic [SQ_W-1:0] SQ_ONE = SQ_W'(1) << (2 * (SQRT_STAGES - 1 - g));
         logic [SQ_W-1:0] n_src, r_src, trial;
         logic            ge;

         if (g == 0) begin : first
            assign n_src = ssum_ff;
            assign r_src = '0;
         end else begin : rest
            assign n_src = rn_ff[g-1];
            assign r_src = rr_ff[g-1];
         end

         assign trial = r_src + SQ_ONE;
         assign ge    = (n_src >= trial);

         always_ff @(posedge clock) begin
            rn_ff[g] <= ge ? n_src - trial : n_src;
            rr_ff[g] <= ge ? (r_src >> 1) + SQ_ONE : (r_src >> 1);
         end
      end
   endgenerate

   // Advance side data beside the square root
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SQRT_STAGES; i++) rvld_ff[i] <= 1'b0;
      end else begin
         rvld_ff[0] <= s_vld_ff;
         for (int i = 1; i < SQRT_STAGES; i++) rvld_ff[i] <= rvld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      rside_ff[0] <= s_side_ff;
      for (int i = 1; i < SQRT_STAGES; i++) rside_ff[i] <= rside_ff[i-1];
   end

   // ---------------- normalize: divide each magnitude by the length ----------------
   logic [MAG_W-1:0]      len;
   logic [DIV_STAGES-1:0] qn [3];
   tail_type              tail_in;
   tail_type              tail_ff [DIV_STAGES];
   logic                  tvld_ff [DIV_STAGES];

   assign len = rr_ff[R_LAST][MAG_W-1:0];

   generate
      for (g = 0; g < 3; g++) begin : norm
         cprg_div u_div_n (
            .clock (clock),
            .num   ((DIV_NUM_W'(rside_ff[R_LAST].mag[g]) << FRAC_BITS) +
                    DIV_NUM_W'(len >> 1)),
            .den   (len),
            .quo   (qn[g])
         );
      end
   endgenerate

   always_comb begin
      tail_in.ok   = rside_ff[R_LAST].ok;
      tail_in.neg  = rside_ff[R_LAST].neg;
      tail_in.flat = (len == '0);
      tail_in.org  = rside_ff[R_LAST].org;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_STAGES; i++) tvld_ff[i] <= 1'b0;
      end else begin
         tvld_ff[0] <= rvld_ff[R_LAST];
         for (int i = 1; i < DIV_STAGES; i++) tvld_ff[i] <= tvld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      tail_ff[0] <= tail_in;
      for (int i = 1; i < DIV_STAGES; i++) tail_ff[i] <= tail_ff[i-1];
   end

   // ---------------- result register ----------------
   tail_type                tl;
   logic signed [VEC_W-1:0] dir_in [3];
   logic signed [VEC_W-1:0] org_in [3];
   logic signed [VEC_W-1:0] dir_out_ff [3];
   logic signed [VEC_W-1:0] org_out_ff [3];
   logic                    rsp_valid_ff, ray_ok_ff;

   assign tl = tail_ff[Q_LAST];

   // Drop everything to zero for a pixel outside the viewport
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (!tl.ok) begin
            dir_in[i] = '0;
            org_in[i] = '0;
         end else begin
            org_in[i] = tl.org[i];
            if (!mode_ff) dir_in[i] = view_c[i];
            else if (tl.flat) dir_in[i] = '0;
            else if (tl.neg[i]) dir_in[i] = -$signed(VEC_W'(qn[i]));
            else dir_in[i] = $signed(VEC_W'(qn[i]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= tvld_ff[Q_LAST];
   end

   always_ff @(posedge clock) begin
      ray_ok_ff <= tl.ok;
      for (int i = 0; i < 3; i++) begin
         dir_out_ff[i] <= dir_in[i];
         org_out_ff[i] <= org_in[i];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ray_valid = ray_ok_ff;
   assign rsp_origin_x  = org_out_ff[0];
   assign rsp_origin_y  = org_out_ff[1];
   assign rsp_origin_z  = org_out_ff[2];
   assign rsp_ray_dir_x = dir_out_ff[0];
   assign rsp_ray_dir_y = dir_out_ff[1];
   assign rsp_ray_dir_z = dir_out_ff[2];

endmodule

FILE: rtl/cprg_checker.sv
// Port-level checks of the pick-ray generator and their bind to the top level.
module cprg_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic                              rsp_ray_valid,
   input logic signed [cprg_pkg::VEC_W-1:0] rsp_origin_x,
   input logic signed [cprg_pkg::VEC_W-1:0] rsp_origin_y,
   input logic signed [cprg_pkg::VEC_W-1:0] rsp_origin_z,
   input logic signed [cprg_pkg::VEC_W-1:0] rsp_ray_dir_x,
   input logic signed [cprg_pkg::VEC_W-1:0] rsp_ray_dir_y,
   input logic signed [cprg_pkg::VEC_W-1:0] rsp_ray_dir_z
);
   import cprg_pkg::*;

   // Every accepted request yields its result after the fixed latency
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##CPRG_LATENCY rsp_valid)
      else $error("accepted request produced no result");

   // No result without a request at the matching earlier edge
   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, CPRG_LATENCY))
      else $error("result strobe without a request");

   // A ray outside the viewport carries all-zero fields
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ray_valid) |->
         (rsp_origin_x == '0 && rsp_origin_y == '0 && rsp_origin_z == '0 &&
          rsp_ray_dir_x == '0 && rsp_ray_dir_y == '0 && rsp_ray_dir_z == '0))
      else $error("invalid ray with nonzero fields");

endmodule

bind camera_pick_ray_generator cprg_checker u_cprg_checker (.*);

FILE: dv/tb_camera_pick_ray_generator.sv
// Self-checking testbench for the camera pick-ray generator.
`timescale 1ns / 1ps

module tb_camera_pick_ray_generator;
   import cprg_pkg::*;

   typedef struct packed {
      logic                    ray_valid;
      logic signed [VEC_W-1:0] ox, oy, oz, dx, dy, dz;
   } ray_type;

   typedef struct {
      logic [PORT_BITS-1:0] x, y;
      logic [SIZE_W-1:0]    w, h;
      bit                   has_ray;
      ray_type              ray;
   } row_type;

   logic clock, reset, start, busy;
   logic [PORT_BITS-1:0] req_pixel_x, req_pixel_y;
   logic [SIZE_W-1:0]    req_port_width, req_port_height;
   logic rsp_valid, rsp_ray_valid;
   logic signed [VEC_W-1:0] rsp_origin_x, rsp_origin_y, rsp_origin_z;
   logic signed [VEC_W-1:0] rsp_ray_dir_x, rsp_ray_dir_y, rsp_ray_dir_z;
   logic csr_we;
   csr_index_type csr_index;
   logic [CSR_W-1:0] csr_wdata;

   camera_pick_ray_generator dut (.*);

   // Shadow copy of the camera registers
   logic        cam_persp;
   logic [18:0] cam_near;
   logic [63:0] cam_pbnd, cam_obnd;
   logic [59:0] cam_eye, cam_left, cam_up, cam_view;

   ray_type pending_rays[$];
   int      mismatches;
   bit      failed;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("TB_ERROR");
      $finish;
   end

   function automatic longint vcomp(logic [59:0] v, int i);
      return longint'($signed(v[40-20*i +: 20]));
   endfunction

   function automatic longint bcomp(logic [63:0] b, int i);
      return longint'($signed(b[48-16*i +: 16]));
   endfunction

   // Floor shift of a signed value
   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_up(longint v);
      return floor_shift(v + (64'sd1 << (FRAC_BITS-1)), FRAC_BITS);
   endfunction

   function automatic longint clip20(longint v);
      if (v > 524287) return 524287;
      if (v < -524288) return -524288;
      return v;
   endfunction

   function automatic longint int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return longint'(r);
   endfunction

   function automatic longint pixel_frac(longint size, longint pos);
      return (((size - 1 - pos) << FRAC_BITS) + size / 2) / size;
   endfunction

   // Compute the ray for one pixel request from the shadow registers
   function automatic ray_type compute_ray(longint x, longint y, longint w, longint h);
      ray_type r;
      longint px, py, u, v, acc, len, q, a;
      longint c[3], org[3], dir[3];
      longint unsigned s;
      logic [63:0] b;
      r = '0;
      if (w == 0 || h == 0 || x >= w || y >= h) return r;
      px = pixel_frac(w, x);
      py = pixel_frac(h, y);
      b = cam_persp ? cam_pbnd : cam_obnd;
      u = round_up(((64'sd1 << FRAC_BITS) - px) * bcomp(b, 0) + px * bcomp(b, 1));
      v = round_up(((64'sd1 << FRAC_BITS) - py) * bcomp(b, 2) + py * bcomp(b, 3));
      for (int i = 0; i < 3; i++) begin
         acc = longint'(cam_near) * vcomp(cam_view, i) + u * vcomp(cam_left, i)
               + v * vcomp(cam_up, i);
         if (cam_persp) begin
            c[i] = round_up(acc);
            org[i] = vcomp(cam_eye, i);
         end else begin
            acc += vcomp(cam_eye, i) << FRAC_BITS;
            org[i] = clip20(round_up(acc));
            dir[i] = vcomp(cam_view, i);
         end
      end
      if (cam_persp) begin
         s = 0;
         for (int i = 0; i < 3; i++) s += longint'(c[i] * c[i]);
         len = int_sqrt(s);
         for (int i = 0; i < 3; i++) begin
            if (len == 0) begin
               dir[i] = 0;
            end else begin
               a = c[i] < 0 ? -c[i] : c[i];
               q = ((a << FRAC_BITS) + len / 2) / len;
               dir[i] = clip20(c[i] < 0 ? -q : q);
            end
         end
      end
      r.ray_valid = 1;
      r.ox = VEC_W'(org[0]); r.oy = VEC_W'(org[1]); r.oz = VEC_W'(org[2]);
      r.dx = VEC_W'(dir[0]); r.dy = VEC_W'(dir[1]); r.dz = VEC_W'(dir[2]);
      return r;
   endfunction

   // Check each result strobe against the oldest expected ray
   always @(posedge clock) begin
      ray_type got, want;
      if (!reset && rsp_valid) begin
         got = {rsp_ray_valid, rsp_origin_x, rsp_origin_y, rsp_origin_z,
                rsp_ray_dir_x, rsp_ray_dir_y, rsp_ray_dir_z};
         if (pending_rays.size() == 0) begin
            failed = 1;
            if (mismatches < 10) $display("unexpected result %h", got);
            mismatches++;
         end else begin
            want = pending_rays.pop_front();
            if (got !== want) begin
               failed = 1;
               if (mismatches < 10)
                  $display("ray mismatch: expected %h got %h", want, got);
               mismatches++;
            end
         end
      end
   end

   // Drop start for a random number of cycles
   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      repeat (n) begin
         @(negedge clock);
         start = 0;
      end
   endtask

   // Present one pixel request and hold it until accepted
   task automatic send_pixel(row_type row);
      ray_type want;
      @(negedge clock);
      req_pixel_x = row.x; req_pixel_y = row.y;
      req_port_width = row.w; req_port_height = row.h;
      start = 1;
      @(posedge clock);
      while (busy) @(posedge clock);
      want = row.has_ray ? row.ray : compute_ray(row.x, row.y, row.w, row.h);
      pending_rays.push_back(want);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      @(negedge clock);
      start = 0;
      while (pending_rays.size() != 0 && guard < 10000) begin
         @(negedge clock);
         guard++;
      end
      repeat (CPRG_LATENCY + 4) @(negedge clock);
   endtask

   // Write one camera register and mirror it
   task automatic write_csr(csr_index_type idx, logic [63:0] val);
      @(negedge clock);
      csr_we = 1; csr_index = idx; csr_wdata = val;
      case (idx)
         CSR_MODE: cam_persp = val[0];
         CSR_NEAR: cam_near = val[18:0];
         CSR_PBND: cam_pbnd = val;
         CSR_OBND: cam_obnd = val;
         CSR_EYE:  cam_eye = val[59:0];
         CSR_LEFT: cam_left = val[59:0];
         CSR_UP:   cam_up = val[59:0];
         default:  cam_view = val[59:0];
      endcase
      @(negedge clock);
      csr_we = 0;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Small unit-ish vector component, occasionally any value
   function automatic logic [19:0] rand_comp();
      if ($urandom_range(0, 7) == 0) return 20'($urandom());
      return 20'($signed($urandom_range(0, 16384)) - 8192);
   endfunction

   function automatic row_type rand_pixel();
      row_type r;
      r.has_ray = 0;
      r.w = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom_range(0, 4096)) :
                                          SIZE_W'($urandom_range(1, 64));
      r.h = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom_range(0, 4096)) :
                                          SIZE_W'($urandom_range(1, 64));
      if ($urandom_range(0, 9) < 8) begin
         r.x = (r.w == 0) ? '0 : PORT_BITS'($urandom_range(0, r.w - 1));
         r.y = (r.h == 0) ? '0 : PORT_BITS'($urandom_range(0, r.h - 1));
      end else begin
         r.x = PORT_BITS'($urandom());
         r.y = PORT_BITS'($urandom());
      end
      return r;
   endfunction

   row_type directed[$];

   initial begin
      row_type r;
      reset = 1; start = 0; csr_we = 0; csr_index = CSR_MODE; csr_wdata = '0;
      req_pixel_x = 0; req_pixel_y = 0; req_port_width = 1; req_port_height = 1;
      mismatches = 0; failed = 0;
      cam_persp = 1; cam_near = 19'd4096;
      cam_pbnd = 64'hF8000800F8000800; cam_obnd = 64'hF8000800F8000800;
      cam_eye = 0; cam_left = 60'd4096 << 40; cam_up = 60'd4096 << 20; cam_view = 60'd4096;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed table: x, y, width, height, typed-in result where obvious
      r.has_ray = 1;
      r.ray = '0;
      r.x = 5; r.y = 0; r.w = 5; r.h = 5; directed.push_back(r);          // outside in x
      r.x = 0; r.y = 9; r.w = 5; r.h = 5; directed.push_back(r);          // outside in y
      r.x = 0; r.y = 0; r.w = 0; r.h = 5; directed.push_back(r);          // zero width
      r.x = 0; r.y = 0; r.w = 5; r.h = 0; directed.push_back(r);          // zero height
      r.x = 4095; r.y = 4095; r.w = 4096; r.h = 4095; directed.push_back(r);
      // Single pixel viewport centers on left/bottom edge: u=-.5 v=-.5 after reset
      r.x = 0; r.y = 0; r.w = 1; r.h = 1; r.has_ray = 0; directed.push_back(r);
      r.x = 4095; r.y = 4095; r.w = 4096; r.h = 4096; directed.push_back(r);
      r.x = 0; r.y = 0; r.w = 4096; r.h = 4096; directed.push_back(r);
      r.x = 2048; r.y = 1; r.w = 4096; r.h = 3; directed.push_back(r);
      foreach (directed[i]) begin
         idle_gap();
         send_pixel(directed[i]);
      end
      drain();

      // Zero-length perspective direction: all axes zero
      write_csr(CSR_VIEW, 0);
      write_csr(CSR_LEFT, 0);
      write_csr(CSR_UP, 0);
      write_csr(CSR_EYE, {20'h7FFFF, 20'h80000, 20'h00001});
      r.has_ray = 1; r.x = 1; r.y = 1; r.w = 3; r.h = 3;
      r.ray = '{1'b1, 20'sh7FFFF, 20'sh80000, 20'sh00001, 0, 0, 0};
      send_pixel(r);
      drain();
      // Orthographic with saturating origin extremes
      write_csr(CSR_MODE, 0);
      write_csr(CSR_NEAR, 19'h7FFFF);
      write_csr(CSR_VIEW, {20'h7FFFF, 20'h80000, 20'h7FFFF});
      write_csr(CSR_OBND, 64'h7FFF_8000_7FFF_8000);
      write_csr(CSR_LEFT, {20'h7FFFF, 20'h80000, 20'h00000});
      write_csr(CSR_UP, {20'h80000, 20'h7FFFF, 20'h00000});
      r.has_ray = 0;
      for (int i = 0; i < 4; i++) begin
         r.x = i; r.y = 3 - i; r.w = 4; r.h = 4;
         send_pixel(r);
      end
      drain();

      // Random phases with a fresh camera setup each time
      for (int phase = 0; phase < 12; phase++) begin
         write_csr(CSR_MODE, (phase == 11) ? 64'hFFFF_FFFF_FFFF_FFFE : rand64());
         write_csr(CSR_NEAR, (phase % 4 == 0) ? rand64() : $urandom_range(0, 16384));
         write_csr(CSR_PBND, (phase % 3 == 0) ? rand64() :
                   {16'($signed($urandom_range(0, 8192)) - 4096),
                    16'($urandom_range(0, 4096)),
                    16'($signed($urandom_range(0, 8192)) - 4096),
                    16'($urandom_range(0, 4096))});
         write_csr(CSR_OBND, rand64());
         write_csr(CSR_EYE, (phase % 3 == 1) ? rand64() : {rand_comp(), rand_comp(), rand_comp()});
         write_csr(CSR_LEFT, (phase % 5 == 2) ? rand64() : {rand_comp(), rand_comp(), rand_comp()});
         write_csr(CSR_UP, {rand_comp(), rand_comp(), rand_comp()});
         write_csr(CSR_VIEW, (phase % 6 == 3) ? rand64() : {rand_comp(), rand_comp(), rand_comp()});
         for (int n = 0; n < 100; n++) begin
            idle_gap();
            send_pixel(rand_pixel());
         end
         drain();
      end

      if (!failed && pending_rays.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/cprg_pkg.sv
rtl/cprg_div.sv
rtl/camera_pick_ray_generator.sv
rtl/cprg_checker.sv
dv/tb_camera_pick_ray_generator.sv
